FILE: rtl/core/tdla_pkg.sv
`default_nettype none
package tdla_pkg;

  localparam int NUM_CFG = 8;

  localparam int NUM_STATES  = 64;
  localparam int MAX_ACTIONS = 8;
  localparam int VALUE_WIDTH = 32;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_SELECT = 2'd2,
    FUNC_UPDATE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_STATE  = 2'd1,
    ST_BAD_ACTION = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_MODE       = 3'd0,
    CFG_NUM_ACT    = 3'd1,
    CFG_LR_INIT    = 3'd2,
    CFG_LR_DECAY   = 3'd3,
    CFG_EPS_INIT   = 3'd4,
    CFG_EPS_DECAY  = 3'd5,
    CFG_DISCOUNT   = 3'd6,
    CFG_WLIMIT     = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_REQ,
    S_SCAN,
    S_TGT_RD,
    S_QSA_RD,
    S_MUL_G,
    S_SUM_D,
    S_MUL_A,
    S_CLAMP,
    S_WRITE,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  state_index;
    logic [2:0]  action_index;
    logic [31:0] entry_value;
    logic [31:0] reward;
    logic [6:0]  random_draw;
    logic [2:0]  random_action;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] updated_value;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        mode;
    logic [3:0]  num_actions;
    logic [16:0] lr_init;
    logic [16:0] lr_decay;
    logic [16:0] eps_init;
    logic [16:0] eps_decay;
    logic [16:0] discount;
    logic [14:0] weight_limit;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic do_start;
    logic do_load;
    logic do_select;
    logic scan_init;
    logic scan_step;
    logic rd_target;
    logic rd_qsa;
    logic mul_gamma;
    logic sum_delta;
    logic mul_alpha;
    logic clamp;
    logic write_back;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic bad_state;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/tdla_ctrl.sv
`default_nettype none
module tdla_ctrl
  import tdla_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic [1:0] func,
  input  wire logic     mode,
  input  wire dp_stat_t stat,
  output logic          busy,
  output dp_cmd_t       cmd
);

  fsm_state_t state_r, state_nxt;
  logic [1:0] func_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (start && !busy) func_r <= func;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (func == FUNC_START || func == FUNC_LOAD) state_nxt = S_DONE;
          else state_nxt = S_SCAN_REQ;
        end
      end
      S_SCAN_REQ: begin
        if (func_r == FUNC_UPDATE && stat.bad_state) state_nxt = S_DONE;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          if (func_r == FUNC_SELECT) state_nxt = S_DONE;
          else state_nxt = S_TGT_RD;
        end
      end
      S_TGT_RD: state_nxt = S_QSA_RD;
      S_QSA_RD: state_nxt = S_MUL_G;
      S_MUL_G:  state_nxt = S_SUM_D;
      S_SUM_D:  state_nxt = S_MUL_A;
      S_MUL_A:  state_nxt = S_CLAMP;
      S_CLAMP:  state_nxt = S_WRITE;
      S_WRITE:  state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.capture   = start;
        cmd.do_start  = start && (func == FUNC_START);
        cmd.do_load   = start && (func == FUNC_LOAD);
      end
      S_SCAN_REQ: cmd.scan_init = 1'b1;
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.do_select = stat.scan_last && func_r == FUNC_SELECT && !mode;
      end
      S_TGT_RD: cmd.rd_target  = 1'b1;
      S_QSA_RD: cmd.rd_qsa     = 1'b1;
      S_MUL_G:  cmd.mul_gamma  = 1'b1;
      S_SUM_D:  cmd.sum_delta  = 1'b1;
      S_MUL_A:  cmd.mul_alpha  = 1'b1;
      S_CLAMP:  cmd.clamp      = 1'b1;
      S_WRITE:  cmd.write_back = 1'b1;
      S_DONE:   cmd.finish     = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/tdla_datapath.sv
`default_nettype none
module tdla_datapath
  import tdla_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire cfg_t      cfg,
  input  wire dp_cmd_t   cmd,
  output dp_stat_t       stat,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int AW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
  localparam int DEPTH = NUM_STATES * MAX_ACTIONS;
  localparam int MW = SW + AW;
  localparam int PW = VALUE_WIDTH + 20;  // product of value by Q1.16 rate
  localparam int DW = VALUE_WIDTH + 3;   // delta headroom
  localparam logic [16:0] ONE = 17'h10000;

  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_data_r;
  logic [MW-1:0] rd_addr;
  logic          wr_en;
  logic [MW-1:0] wr_addr;
  logic signed [VALUE_WIDTH-1:0] wr_data;

  in_item_t item_r;
  logic [5:0] cur_state_r;
  logic [2:0] cur_action_r;
  logic [16:0] lr_r, eps_r;
  logic [2:0]  next_a_r;

  // scan
  logic [AW:0] scan_idx_r;       // address being presented
  logic        scan_rd_v_r;
  logic [AW:0] scan_rd_idx_r;
  logic signed [VALUE_WIDTH-1:0] best_v_r;
  logic [2:0]  best_a_r;
  logic        explore_r;

  logic signed [VALUE_WIDTH-1:0] target_r, qsa_r, nv_r;
  logic signed [PW-1:0] prod_r;
  logic signed [DW-1:0] delta_r;
  logic signed [DW+1:0] nv_wide_r;
  logic [1:0] status_r;

  logic [3:0] na;
  logic [2:0] rnd_sat;
  logic       explore;
  logic       state_bad;

  always_comb begin
    if (cfg.num_actions == 4'd0) na = 4'd1;
    else if ({28'd0, cfg.num_actions} > MAX_ACTIONS) na = 4'(MAX_ACTIONS);
    else na = cfg.num_actions;
    rnd_sat = ({1'b0, item_r.random_action} > na - 4'd1) ? 3'(na - 4'd1)
            : item_r.random_action;
    explore = ({item_r.random_draw, 16'd0} <= 23'(eps_r) * 23'd100);
    state_bad = ({26'd0, item_r.state_index} >= NUM_STATES);
  end

  assign stat.bad_state = state_bad;
  assign stat.scan_last = scan_rd_v_r && (scan_rd_idx_r + 1'b1 >= (AW+1)'(na));

  // memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  logic [5:0] scan_row;
  always_comb begin
    scan_row = (cmd.scan_init && item_r.func == FUNC_SELECT && 1'b1) ? cur_state_r
             : item_r.state_index;
    if (item_r.func == FUNC_SELECT) scan_row = cur_state_r;
    // present the first column of the row while the scan is set up
    rd_addr = {SW'(scan_row), (cmd.scan_init ? AW'(0) : scan_idx_r[AW-1:0])};
    if (cmd.rd_target) begin
      rd_addr = {SW'(item_r.state_index),
                 (cfg.mode ? AW'(next_a_r) : AW'(best_a_r))};
    end
    if (cmd.rd_qsa) rd_addr = {SW'(cur_state_r), AW'(cur_action_r)};
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {SW'(cur_state_r), AW'(cur_action_r)};
    wr_data = nv_r;
    if (cmd.do_load && !({26'd0, in_item.state_index} >= NUM_STATES)
        && ({1'b0, in_item.action_index} < na)) begin
      wr_en   = 1'b1;
      wr_addr = {SW'(in_item.state_index), AW'(in_item.action_index)};
      wr_data = VALUE_WIDTH'(signed'(in_item.entry_value));
    end
    if (cmd.finish && item_r.func == FUNC_UPDATE && status_r == ST_OK) wr_en = 1'b1;
  end

  logic signed [VALUE_WIDTH+1:0] lim;
  logic signed [PW+16:0] q_full;
  logic signed [DW+1:0]  nv_sum;
  always_comb begin
    lim = $signed({2'b00, VALUE_WIDTH'({cfg.weight_limit, 16'd0})});
    if ({17'd0, cfg.weight_limit, 16'd0} > ((48'd1 << (VALUE_WIDTH-1)) - 48'd1))
      lim = $signed((VALUE_WIDTH+2)'((48'd1 << (VALUE_WIDTH-1)) - 48'd1));
    q_full = (PW+17)'(prod_r) + (PW+17)'(32768);
    nv_sum = (DW+2)'(qsa_r) + (DW+2)'(q_full >>> 16);
  end

  logic signed [VALUE_WIDTH-1:0] rd_q;
  assign rd_q = rd_data_r;

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (!rst_n) begin
      cur_state_r  <= '0;
      cur_action_r <= '0;
      lr_r         <= 17'd32768;
      eps_r        <= 17'd13107;
      scan_rd_v_r  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        item_r   <= in_item;
        status_r <= ST_OK;
        nv_r     <= '0;
        if ({26'd0, in_item.state_index} >= NUM_STATES && in_item.func != FUNC_SELECT)
          status_r <= ST_BAD_STATE;
        else if (in_item.func == FUNC_LOAD) begin
          if ({1'b0, in_item.action_index} >= na) status_r <= ST_BAD_ACTION;
          else nv_r <= VALUE_WIDTH'(signed'(in_item.entry_value));
        end
      end
      if (cmd.do_start && !({26'd0, in_item.state_index} >= NUM_STATES)) begin
        cur_state_r <= in_item.state_index;
        lr_r  <= (cfg.lr_init > ONE) ? ONE : cfg.lr_init;
        eps_r <= (cfg.eps_init > ONE) ? ONE : cfg.eps_init;
        if (cfg.mode) begin
          cur_action_r <= ({1'b0, in_item.random_action} > na - 4'd1) ? 3'(na - 4'd1)
                        : in_item.random_action;
        end
      end
      if (cmd.scan_init) begin
        scan_idx_r  <= (AW+1)'(1);
        scan_rd_v_r <= 1'b1;
        scan_rd_idx_r <= '0;
        explore_r   <= explore;
        next_a_r    <= cur_action_r;
      end
      if (cmd.scan_step) begin
        scan_idx_r    <= scan_idx_r + 1'b1;
        scan_rd_idx_r <= scan_rd_idx_r + 1'b1;
        if (scan_rd_idx_r == '0 || rd_q > best_v_r) begin
          best_v_r <= rd_q;
          best_a_r <= 3'(scan_rd_idx_r);
        end
        if (stat.scan_last) begin
          scan_rd_v_r <= 1'b0;
          if (cfg.mode) begin
            next_a_r <= explore_r ? rnd_sat
                      : ((scan_rd_idx_r == '0 || rd_q > best_v_r) ? 3'(scan_rd_idx_r)
                         : best_a_r);
          end
        end
      end
      if (cmd.do_select) begin
        cur_action_r <= explore_r ? rnd_sat
                      : ((scan_rd_idx_r == '0 || rd_q > best_v_r) ? 3'(scan_rd_idx_r)
                         : best_a_r);
      end
      if (cmd.rd_qsa) begin
        // Q-learning target is the row maximum; SARSA reads it from the table
        target_r <= cfg.mode ? rd_q : best_v_r;
      end
      if (cmd.mul_gamma) begin
        qsa_r  <= rd_q;
        prod_r <= PW'(target_r) * PW'($signed({1'b0, cfg.discount}));
      end
      if (cmd.sum_delta) begin
        delta_r <= DW'(signed'(item_r.reward)) + DW'(q_full >>> 16) - DW'(qsa_r);
      end
      if (cmd.mul_alpha) begin
        prod_r <= PW'(delta_r) * PW'($signed({1'b0, lr_r}));
      end
      if (cmd.clamp) begin
        nv_wide_r <= nv_sum;
      end
      if (cmd.write_back) begin
        if (nv_wide_r > (DW+2)'(lim)) nv_r <= VALUE_WIDTH'(lim);
        else if (nv_wide_r < -(DW+2)'(lim)) nv_r <= VALUE_WIDTH'(-lim);
        else nv_r <= VALUE_WIDTH'(nv_wide_r);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (item_r.func == FUNC_UPDATE && status_r == ST_OK) begin
          cur_state_r  <= item_r.state_index;
          cur_action_r <= next_a_r;
          eps_r <= (eps_r > cfg.eps_decay) ? eps_r - cfg.eps_decay : 17'd0;
          lr_r  <= (lr_r > cfg.lr_decay) ? lr_r - cfg.lr_decay : 17'd0;
        end
      end
    end
  end

  // the clamped value is written on the cycle after it is formed
  always_comb begin
    out_item.action        = cur_action_r;
    out_item.updated_value = 32'(nv_r);
    out_item.status        = status_r;
  end

endmodule
`default_nettype wire

FILE: rtl/core/tabular_td_learning_agent_top.sv
`default_nettype none
// Tabular Q-learning / SARSA agent.
// Input channel: drive in_item with start high; the transaction is taken when
// busy is low. Result: out_valid pulses for one cycle with out_item; the
// receiver cannot stall, so results are never held.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Write only while idle.
// Sequencing: start and load go straight to done; select scans the row;
// update scans a row through the single table read port, then does two
// dependent multiplies and a write-back. One item at a time.
// Reset (synchronous, rst_n low): the configuration returns to its defaults, the
// current state and action clear and the rates take their reset values. The
// table is not cleared; every entry must be loaded before it is read.
module tabular_td_learning_agent_top
  import tdla_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= 1'b0;
      cfg_r.num_actions  <= 4'd1;
      cfg_r.lr_init      <= 17'd32768;
      cfg_r.lr_decay     <= 17'd0;
      cfg_r.eps_init     <= 17'd13107;
      cfg_r.eps_decay    <= 17'd66;
      cfg_r.discount     <= 17'd6554;
      cfg_r.weight_limit <= 15'd200;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:      cfg_r.mode         <= cfg_data[0];
        CFG_NUM_ACT:   cfg_r.num_actions  <= cfg_data[3:0];
        CFG_LR_INIT:   cfg_r.lr_init      <= cfg_data[16:0];
        CFG_LR_DECAY:  cfg_r.lr_decay     <= cfg_data[16:0];
        CFG_EPS_INIT:  cfg_r.eps_init     <= cfg_data[16:0];
        CFG_EPS_DECAY: cfg_r.eps_decay    <= cfg_data[16:0];
        CFG_DISCOUNT:  cfg_r.discount     <= cfg_data[16:0];
        CFG_WLIMIT:    cfg_r.weight_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  tdla_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_item.func),
    .mode  (cfg_r.mode),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  tdla_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status != 2'd3))
    else $error("undefined status code");

endmodule
`default_nettype wire
